// ===== hdl/g711_pkg.sv =====
// G.711 companding package: conversion kinds, segment constants and transcoding ROMs.
// Used by g711_companding_codec. No dependencies.
package g711_pkg;

    typedef enum logic [2:0] {
        KIND_LIN_TO_ULAW  = 3'd0,
        KIND_ULAW_TO_LIN  = 3'd1,
        KIND_LIN_TO_ALAW  = 3'd2,
        KIND_ALAW_TO_LIN  = 3'd3,
        KIND_ALAW_TO_ULAW = 3'd4,
        KIND_ULAW_TO_ALAW = 3'd5
    } t_kind;

    localparam logic [14:0] ULAW_BIAS = 15'd132;
    localparam logic [15:0] ULAW_CLIP = 16'd32635;
    localparam logic [6:0]  ALAW_XOR  = 7'h55;
    localparam logic [8:0]  ALAW_SEG0_OFS = 9'h008;
    localparam logic [8:0]  ALAW_SEGN_OFS = 9'h108;

    localparam logic [14:0] ULAW_SEG_BASE [8] = '{
        15'd0, 15'd132, 15'd396, 15'd924, 15'd1980, 15'd4092, 15'd8316, 15'd16764
    };

    localparam logic [7:0] ROM_MU_TO_A [128] = '{
        8'd1, 8'd1, 8'd2, 8'd2, 8'd3, 8'd3, 8'd4, 8'd4,
        8'd5, 8'd5, 8'd6, 8'd6, 8'd7, 8'd7, 8'd8, 8'd8,
        8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16,
        8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24,
        8'd25, 8'd27, 8'd29, 8'd31, 8'd33, 8'd34, 8'd35, 8'd36,
        8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43, 8'd44,
        8'd46, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54,
        8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62,
        8'd64, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71,
        8'd72, 8'd73, 8'd74, 8'd75, 8'd76, 8'd77, 8'd78, 8'd79,
        8'd81, 8'd82, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87, 8'd88,
        8'd89, 8'd90, 8'd91, 8'd92, 8'd93, 8'd94, 8'd95, 8'd96,
        8'd97, 8'd98, 8'd99, 8'd100, 8'd101, 8'd102, 8'd103, 8'd104,
        8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112,
        8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120,
        8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128
    };

    localparam logic [6:0] ROM_A_TO_MU [128] = '{
        7'd1, 7'd3, 7'd5, 7'd7, 7'd9, 7'd11, 7'd13, 7'd15,
        7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23,
        7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29, 7'd30, 7'd31,
        7'd32, 7'd32, 7'd33, 7'd33, 7'd34, 7'd34, 7'd35, 7'd35,
        7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42, 7'd43,
        7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd48, 7'd49, 7'd49,
        7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57,
        7'd58, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd64,
        7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71, 7'd72,
        7'd73, 7'd74, 7'd75, 7'd76, 7'd77, 7'd78, 7'd79, 7'd79,
        7'd80, 7'd81, 7'd82, 7'd83, 7'd84, 7'd85, 7'd86, 7'd87,
        7'd88, 7'd89, 7'd90, 7'd91, 7'd92, 7'd93, 7'd94, 7'd95,
        7'd96, 7'd97, 7'd98, 7'd99, 7'd100, 7'd101, 7'd102, 7'd103,
        7'd104, 7'd105, 7'd106, 7'd107, 7'd108, 7'd109, 7'd110, 7'd111,
        7'd112, 7'd113, 7'd114, 7'd115, 7'd116, 7'd117, 7'd118, 7'd119,
        7'd120, 7'd121, 7'd122, 7'd123, 7'd124, 7'd125, 7'd126, 7'd127
    };

    // segment number = position of leading one in bits 14..8, else 0
    function automatic logic [2:0] seg_of(input logic [14:0] v);
        logic [2:0] s;
        s = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if (v[k+7]) begin
                s = 3'(k);
            end
        end
        return s;
    endfunction

endpackage

// ===== hdl/g711_companding_codec.sv =====
// G.711 companding codec top level: mu-law / A-law encode, decode and transcode.
// Depends on g711_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one beat per conversion:
//   i_kind selects the conversion, i_linear_in is read by the encode kinds,
//   i_code_in by the decode and transcode kinds.
//   Output channel (o_out_valid / i_out_ready) returns exactly one beat per
//   input beat, in order: o_linear_out for decode kinds, o_code_out for
//   encode and transcode kinds, the unused field is zero. Kinds 6 and 7
//   return a beat with both fields zero.
//   Path from input beat to output valid: input register, then result register.
//   Throughput: one beat per cycle while the receiver holds i_out_ready high,
//   set by the single conversion stage between the two registers.
//   Reset clears both valid flags; the block is ready the cycle after reset.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more beat; o_in_ready drops only when both
//   are full.
module g711_companding_codec (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic signed [15:0] i_linear_in,
    input  logic [7:0]         i_code_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_linear_out,
    output logic [7:0]         o_code_out
);
    import g711_pkg::*;

    logic               r_s1_valid;
    t_kind              r_s1_kind;
    logic signed [15:0] r_s1_lin;
    logic [7:0]         r_s1_code;
    logic               r_out_valid;
    logic signed [15:0] r_out_lin;
    logic [7:0]         r_out_code;
    logic signed [15:0] n_out_lin;
    logic [7:0]         n_out_code;
    logic               s1_adv;

    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_kind <= t_kind'(i_kind);
            r_s1_lin  <= i_linear_in;
            r_s1_code <= i_code_in;
        end
    end

    // mu-law encode
    logic [15:0] ue_mag;
    logic [15:0] ue_clip;
    logic [14:0] ue_b;
    logic [2:0]  ue_e;
    logic [14:0] ue_sh;
    logic [7:0]  ue_code;

    always_comb begin
        ue_mag  = r_s1_lin[15] ? 16'(-r_s1_lin) : 16'(r_s1_lin);
        ue_clip = (ue_mag > ULAW_CLIP) ? ULAW_CLIP : ue_mag;
        ue_b    = ue_clip[14:0] + ULAW_BIAS;
        ue_e    = seg_of(ue_b);
        ue_sh   = ue_b >> (4'(ue_e) + 4'd3);
        ue_code = ~{r_s1_lin[15], ue_e, ue_sh[3:0]};
    end

    // mu-law decode
    logic [7:0]  ud_c;
    logic [2:0]  ud_e;
    logic [14:0] ud_v;
    logic [15:0] ud_lin;

    always_comb begin
        ud_c   = ~r_s1_code;
        ud_e   = ud_c[6:4];
        ud_v   = ULAW_SEG_BASE[ud_e] + (15'(ud_c[3:0]) << (4'(ud_e) + 4'd3));
        ud_lin = ud_c[7] ? 16'(-{1'b0, ud_v}) : {1'b0, ud_v};
    end

    // A-law encode; small negatives clamp to magnitude zero
    logic signed [16:0] ae_neg;
    logic [14:0]        ae_m;
    logic [2:0]         ae_seg;
    logic [14:0]        ae_sh;
    logic [3:0]         ae_q;
    logic [7:0]         ae_code;

    always_comb begin
        ae_neg = -17'(r_s1_lin) - 17'sd8;
        if (!r_s1_lin[15]) begin
            ae_m = r_s1_lin[14:0];
        end else if (ae_neg[16]) begin
            ae_m = 15'd0;
        end else begin
            ae_m = ae_neg[14:0];
        end
        ae_seg  = seg_of(ae_m);
        ae_sh   = ae_m >> (4'(ae_seg) + 4'd3);
        ae_q    = (ae_seg < 3'd2) ? ae_m[7:4] : ae_sh[3:0];
        ae_code = {~r_s1_lin[15], ae_seg ^ ALAW_XOR[6:4], ae_q ^ ALAW_XOR[3:0]};
    end

    // A-law decode
    logic [7:0]  ad_a;
    logic [2:0]  ad_seg;
    logic [8:0]  ad_t;
    logic [14:0] ad_v;
    logic [15:0] ad_lin;

    always_comb begin
        ad_a   = r_s1_code ^ {1'b0, ALAW_XOR};
        ad_seg = ad_a[6:4];
        ad_t   = {1'b0, ad_a[3:0], 4'b0}
               + ((ad_seg == 3'd0) ? ALAW_SEG0_OFS : ALAW_SEGN_OFS);
        ad_v   = (ad_seg > 3'd1) ? (15'(ad_t) << (ad_seg - 3'd1)) : 15'(ad_t);
        ad_lin = ad_a[7] ? {1'b0, ad_v} : 16'(-{1'b0, ad_v});
    end

    // transcoding through the ROMs
    logic [7:0] am_code;
    logic [7:0] ma_rom;
    logic [7:0] ma_m1;
    logic [7:0] ma_code;

    always_comb begin
        am_code = {r_s1_code[7], ~ROM_A_TO_MU[r_s1_code[6:0] ^ ALAW_XOR]};
        ma_rom  = ROM_MU_TO_A[~r_s1_code[6:0]];
        ma_m1   = ma_rom - 8'd1;
        ma_code = {r_s1_code[7], ma_m1[6:0] ^ ALAW_XOR};
    end

    always_comb begin
        n_out_lin  = '0;
        n_out_code = '0;
        case (r_s1_kind)
            KIND_LIN_TO_ULAW:  n_out_code = ue_code;
            KIND_ULAW_TO_LIN:  n_out_lin  = ud_lin;
            KIND_LIN_TO_ALAW:  n_out_code = ae_code;
            KIND_ALAW_TO_LIN:  n_out_lin  = ad_lin;
            KIND_ALAW_TO_ULAW: n_out_code = am_code;
            KIND_ULAW_TO_ALAW: n_out_code = ma_code;
            default: begin
                n_out_lin  = '0;
                n_out_code = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_lin  <= n_out_lin;
            r_out_code <= n_out_code;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_linear_out = r_out_lin;
    assign o_code_out   = r_out_code;

    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_s1_valid && r_out_valid && !i_out_ready)
        else $error("input stalled without both stages full");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_kind)
                                  && $stable(r_s1_code) && $stable(r_s1_lin))
        else $error("input stage lost a held beat");

    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_code_out != 8'd0) |-> o_linear_out == 16'sd0)
        else $error("both result fields nonzero");

endmodule
